[design/mat_pkg.sv]
// ----------------------------------------------------------------------------
// mat_pkg
// Shared constants and types of the moving average threshold block.
// ----------------------------------------------------------------------------
package mat_pkg;

    localparam int WINDOW_MAX_DEF = 64;

    localparam int PIX_W     = 8;
    localparam int LEN_W     = 7;
    localparam int SCALE_W   = 10;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int PIX_MAX   = 255;

    localparam logic [LEN_W-1:0]   WINDOW_LEN_RST = 7'd10;
    localparam logic [SCALE_W-1:0] SCALE_RST      = 10'd205;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_SCALE = 1'b1;

    // How the back end has to update the window sum for a word.
    typedef enum logic [1:0] {
        K_START = 2'd0,
        K_SLIDE = 2'd1,
        K_RESUM = 2'd2
    } t_kind;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        t_kind            kind;
        logic [LEN_W-1:0] len;
    } t_item;

endpackage

[design/mat_ram.sv]
// ----------------------------------------------------------------------------
// mat_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/mat_front.sv]
// ----------------------------------------------------------------------------
// mat_front
// Accepts pixels, works out the effective window length and how the sum
// must be updated, and holds the words in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module mat_front #(
    parameter int WINDOW_MAX = mat_pkg::WINDOW_MAX_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [mat_pkg::PIX_W-1:0]   i_pixel,
    input  logic                        i_frame_start,
    input  logic [mat_pkg::LEN_W-1:0]   i_window_len,
    output logic                        o_valid,
    output mat_pkg::t_item              o_item,
    input  logic                        i_take
);

    mat_pkg::t_item              r_q [2];
    logic                        r_wp;
    logic                        r_rp;
    logic [1:0]                  r_cnt;
    logic [mat_pkg::LEN_W-1:0]   r_len_last;

    logic [mat_pkg::LEN_W-1:0]   eff_len;
    mat_pkg::t_item              n_item;
    logic                        accept;
    logic                        deq;
    logic [1:0]                  n_cnt;

    always_comb begin
        if (i_window_len == '0) begin
            eff_len = mat_pkg::LEN_W'(1);
        end else if (32'(i_window_len) > WINDOW_MAX) begin
            eff_len = mat_pkg::LEN_W'(WINDOW_MAX);
        end else begin
            eff_len = i_window_len;
        end
    end

    // A change of window length invalidates the running sum, so the back end
    // rebuilds it from the stored pixels.
    always_comb begin
        n_item.pixel = i_pixel;
        n_item.len   = eff_len;
        if (i_frame_start) begin
            n_item.kind = mat_pkg::K_START;
        end else if (eff_len != r_len_last) begin
            n_item.kind = mat_pkg::K_RESUM;
        end else begin
            n_item.kind = mat_pkg::K_SLIDE;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign accept  = i_push && !o_full;
    assign deq     = i_take && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (accept && !deq) begin
            n_cnt = r_cnt + 2'd1;
        end else if (deq && !accept) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= 1'b0;
            r_rp       <= 1'b0;
            r_cnt      <= 2'd0;
            r_len_last <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_wp       <= ~r_wp;
                r_len_last <= eff_len;
            end
            if (deq) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= n_item;
        end
    end

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= 2'd2))
        else $error("front queue count out of range");
`endif

endmodule

[design/mat_back.sv]
// ----------------------------------------------------------------------------
// mat_back
// Keeps the pixel ring and the window sum, forms the threshold comparison
// and queues the results.
// ----------------------------------------------------------------------------
module mat_back #(
    parameter int WINDOW_MAX = mat_pkg::WINDOW_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  mat_pkg::t_item               i_item,
    output logic                         o_take,
    input  logic [mat_pkg::SCALE_W-1:0]  i_scale,
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic                         o_foreground
);

    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = $clog2(mat_pkg::PIX_MAX * WINDOW_MAX + 1);
    localparam int RHS_W = mat_pkg::PIX_W + 8;
    localparam int P1_W  = mat_pkg::SCALE_W + SUM_W;
    localparam int P2_W  = mat_pkg::LEN_W + RHS_W;
    localparam int P_W   = (P1_W > P2_W) ? P1_W : P2_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_UPD  = 5'b00010,
        ST_SCAN = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_CMP  = 5'b10000
    } t_state;

    t_state                       r_state;
    logic [mat_pkg::PIX_W-1:0]    r_px;
    mat_pkg::t_kind               r_kind;
    logic [mat_pkg::LEN_W-1:0]    r_len;
    logic [IDX_W-1:0]             r_slot;
    logic [CNT_W-1:0]             r_seen;
    logic [SUM_W-1:0]             r_sum;
    logic [mat_pkg::LEN_W-1:0]    r_cnt;
    logic [IDX_W-1:0]             r_addr;
    logic                         r_pend;
    logic [P1_W-1:0]              r_p1;
    logic [P2_W-1:0]              r_p2;
    logic                         r_ob [2];
    logic                         r_owp;
    logic                         r_orp;
    logic [1:0]                   r_ocnt;

    logic [IDX_W-1:0]             raddr;
    logic [mat_pkg::PIX_W-1:0]    rdata;
    logic                         ram_we;
    logic [CNT_W-1:0]             n_seen;
    logic [mat_pkg::LEN_W-1:0]    n_valid;
    logic                         drop;
    logic [RHS_W-1:0]             rhs;
    logic                         fg;
    logic                         opush;
    logic                         opop;

    function automatic logic [IDX_W-1:0] f_prev(input logic [IDX_W-1:0] a);
        logic [IDX_W-1:0] r;
        if (a == '0) begin
            r = IDX_W'(WINDOW_MAX - 1);
        end else begin
            r = a - IDX_W'(1);
        end
        return r;
    endfunction

    // Slot that held the pixel l places before slot s in the ring.
    function automatic logic [IDX_W-1:0] f_back(input logic [IDX_W-1:0] s,
                                                input logic [mat_pkg::LEN_W-1:0] l);
        int t;
        t = int'(s) - int'(l);
        if (t < 0) begin
            t = t + WINDOW_MAX;
        end
        return IDX_W'(t);
    endfunction

    mat_ram #(
        .WIDTH (mat_pkg::PIX_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_px),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_take = (r_state == ST_IDLE) && i_valid && (r_ocnt != 2'd2);
    assign raddr  = (r_state == ST_SCAN) ? r_addr : f_back(r_slot, i_item.len);
    assign ram_we = (r_state == ST_UPD);

    always_comb begin
        if (32'(r_seen) < WINDOW_MAX) begin
            n_seen = r_seen + CNT_W'(1);
        end else begin
            n_seen = r_seen;
        end
        if (32'(n_seen) < 32'(r_len)) begin
            n_valid = mat_pkg::LEN_W'(n_seen);
        end else begin
            n_valid = r_len;
        end
    end

    // The oldest pixel leaves the window once the window is full.
    assign drop = (32'(r_seen) >= 32'(r_len));

    // px > floor((s*sum + 128L) / 256L) holds exactly when s*sum < L*(256px - 128).
    assign rhs = {r_px, 8'd0} - RHS_W'(128);
    assign fg  = (r_px != '0) && (P_W'(r_p1) < P_W'(r_p2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_slot  <= '0;
            r_seen  <= '0;
            r_sum   <= '0;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (o_take) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_slot <= (32'(r_slot) == WINDOW_MAX - 1) ? '0 : r_slot + IDX_W'(1);
                    case (r_kind)
                        mat_pkg::K_START: begin
                            r_seen  <= CNT_W'(1);
                            r_sum   <= SUM_W'(r_px);
                            r_state <= ST_MUL;
                        end
                        mat_pkg::K_SLIDE: begin
                            r_seen  <= n_seen;
                            r_sum   <= r_sum + SUM_W'(r_px) - (drop ? SUM_W'(rdata) : '0);
                            r_state <= ST_MUL;
                        end
                        mat_pkg::K_RESUM: begin
                            r_seen <= n_seen;
                            r_sum  <= SUM_W'(r_px);
                            r_cnt  <= n_valid - mat_pkg::LEN_W'(1);
                            r_addr <= f_prev(r_slot);
                            r_pend <= 1'b0;
                            if (n_valid == mat_pkg::LEN_W'(1)) begin
                                r_state <= ST_MUL;
                            end else begin
                                r_state <= ST_SCAN;
                            end
                        end
                        default: begin
                            r_state <= ST_MUL;
                        end
                    endcase
                end
                ST_SCAN: begin
                    // One ring read is issued per cycle; its data is added in the
                    // cycle after.
                    if (r_pend) begin
                        r_sum <= r_sum + SUM_W'(rdata);
                    end
                    if (r_cnt != '0) begin
                        r_addr <= f_prev(r_addr);
                        r_cnt  <= r_cnt - mat_pkg::LEN_W'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_px   <= i_item.pixel;
            r_kind <= i_item.kind;
            r_len  <= i_item.len;
        end
        if (r_state == ST_MUL) begin
            r_p1 <= i_scale * r_sum;
            r_p2 <= r_len * rhs;
        end
    end

    // Result queue: room is checked before a word is taken, so a push
    // always finds a free entry.
    assign opush        = (r_state == ST_CMP);
    assign opop         = i_pop && (r_ocnt != 2'd0);
    assign o_empty      = (r_ocnt == 2'd0);
    assign o_foreground = r_ob[r_orp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (opush) begin
                r_owp <= ~r_owp;
            end
            if (opop) begin
                r_orp <= ~r_orp;
            end
            if (opush && !opop) begin
                r_ocnt <= r_ocnt + 2'd1;
            end else if (opop && !opush) begin
                r_ocnt <= r_ocnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (opush) begin
            r_ob[r_owp] <= fg;
        end
    end

`ifndef ASSERT_OFF
    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ocnt <= 2'd2))
        else $error("result queue count out of range");

    a_scan_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_cnt != '0 || r_pend))
        else $error("scan state entered with nothing to read");

    a_seen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_seen) <= WINDOW_MAX))
        else $error("pixel count beyond ring depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (r_ocnt != 2'd2 || $past(opop)))
        else $error("result pushed into a full queue");
`endif

endmodule

[design/moving_average_threshold.sv]
// The back end takes a new pixel word only once it is through with the last one:
// it steps through take, update, multiply and compare around the ring memory's read.
// After a window length change the next pixel also passes a scan step, with one ring
// read per stored pixel of the new window beyond the newest one.
// Reset is synchronous, empties both queues and the window; the ring is not cleared.
// ----------------------------------------------------------------------------
// moving_average_threshold
// Marks grey pixels as foreground against a scaled moving average.
// ----------------------------------------------------------------------------
module moving_average_threshold #(
    parameter int WINDOW_MAX = mat_pkg::WINDOW_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [mat_pkg::PIX_W-1:0]        i_pixel,
    input  logic                             i_frame_start,
    output logic                             empty,
    input  logic                             pop,
    output logic                             o_foreground,
    input  logic                             i_cfg_we,
    input  logic [mat_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mat_pkg::CFG_W-1:0]        i_cfg_data
);

    logic [mat_pkg::LEN_W-1:0]   r_window_len;
    logic [mat_pkg::SCALE_W-1:0] r_threshold_scale;

    logic           q_valid;
    logic           q_take;
    mat_pkg::t_item q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len      <= mat_pkg::WINDOW_LEN_RST;
            r_threshold_scale <= mat_pkg::SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mat_pkg::CFG_WINDOW_LEN: begin
                    r_window_len <= i_cfg_data[mat_pkg::LEN_W-1:0];
                end
                mat_pkg::CFG_THRESHOLD_SCALE: begin
                    r_threshold_scale <= i_cfg_data[mat_pkg::SCALE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    mat_front #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .i_window_len  (r_window_len),
        .o_valid       (q_valid),
        .o_item        (q_item),
        .i_take        (q_take)
    );

    mat_back #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_item       (q_item),
        .o_take       (q_take),
        .i_scale      (r_threshold_scale),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_foreground (o_foreground)
    );

endmodule

[tb/moving_average_threshold_checker.sv]
// ----------------------------------------------------------------------------
// moving_average_threshold_checker
// Watches the pixel, result and register ports of the moving average threshold
// block, predicts the foreground flag of every accepted pixel word and compares
// it with the result words in order.
// ----------------------------------------------------------------------------
module moving_average_threshold_checker
    import mat_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    input  logic                 full,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic                 i_frame_start,
    input  logic                 empty,
    input  logic                 pop,
    input  logic                 o_foreground,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   errors,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = WINDOW_MAX_DEF;

    logic [PIX_W-1:0]   ring [RING_DEPTH];
    int unsigned        ring_ptr;
    int unsigned        frame_fill;
    logic [LEN_W-1:0]   cfg_len;
    logic [SCALE_W-1:0] cfg_scale;
    logic               foreground_due [$];
    logic               want;
    int                 err_count = 0;

    assign errors = err_count;

    // Updates the window with one pixel and returns its foreground flag.
    function automatic logic forecast_foreground(input logic [PIX_W-1:0] px,
                                                 input logic fs);
        int unsigned len;
        int unsigned span;
        int unsigned total;
        int unsigned cut;
        len = (cfg_len == 0) ? 1 : ((cfg_len > RING_DEPTH) ? RING_DEPTH : cfg_len);
        if (fs)
            frame_fill = 0;
        ring[ring_ptr] = px;
        if (frame_fill < RING_DEPTH)
            frame_fill++;
        span = (frame_fill < len) ? frame_fill : len;
        total = 0;
        // Only pixels of the current frame are summed, newest first.
        for (int k = 0; k < span; k++)
            total += ring[(ring_ptr + RING_DEPTH - k) % RING_DEPTH];
        ring_ptr = (ring_ptr + 1) % RING_DEPTH;
        // Scaled mean in Q8, rounded to nearest with halves going up.
        cut = (cfg_scale * total + 128 * len) / (256 * len);
        return px > cut;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_len    = WINDOW_LEN_RST;
            cfg_scale  = SCALE_RST;
            ring_ptr   = 0;
            frame_fill = 0;
            foreground_due.delete();
            for (int k = 0; k < RING_DEPTH; k++)
                ring[k] = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WINDOW_LEN:      cfg_len   = i_cfg_data[LEN_W-1:0];
                    CFG_THRESHOLD_SCALE: cfg_scale = i_cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (push && !full)
                foreground_due.push_back(forecast_foreground(i_pixel, i_frame_start));
            if (pop && !empty) begin
                if (foreground_due.size() == 0) begin
                    $error("foreground: no word expected, actual %0b", o_foreground);
                    err_count++;
                end else begin
                    want = foreground_due.pop_front();
                    if (want !== o_foreground) begin
                        $error("foreground: expected %0b, actual %0b", want, o_foreground);
                        err_count++;
                    end
                end
            end
        end
        // Registered so that readers never race the update above.
        outstanding <= foreground_due.size();
    end

endmodule

[tb/moving_average_threshold_tb.sv]
// ----------------------------------------------------------------------------
// moving_average_threshold_tb
// Drives pixel frames and register settings into the moving average threshold
// block with random gaps and back-pressure; the checker beside it predicts and
// compares every foreground word.
// ----------------------------------------------------------------------------
module moving_average_threshold_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mat_pkg::*;

    localparam int PIXEL_TOTAL = 1750;
    localparam int CALM_TAIL   = 200;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 push          = 1'b0;
    logic [PIX_W-1:0]     i_pixel       = '0;
    logic                 i_frame_start = 1'b0;
    logic                 pop           = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = CFG_WINDOW_LEN;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    wire                  full;
    wire                  empty;
    wire                  o_foreground;
    int                   errors;
    int                   outstanding;

    bit feed_gaps    = 1'b1;
    bit drain_stalls = 1'b1;
    int stall_left   = 0;

    moving_average_threshold uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .empty         (empty),
        .pop           (pop),
        .o_foreground  (o_foreground),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    moving_average_threshold_checker fg_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .empty         (empty),
        .pop           (pop),
        .o_foreground  (o_foreground),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .errors        (errors),
        .outstanding   (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: pop stays high except during random stall bursts.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            pop        <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (drain_stalls && $urandom_range(0, 5) == 0) begin
            pop        <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic feed(input logic [PIX_W-1:0] px, input logic fs);
        if (feed_gaps && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_pixel       <= px;
        i_frame_start <= fs;
        do @(posedge i_clk); while (full);
    endtask

    // Holds the sender back until every expected word has come out.
    task automatic settle();
        push <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic configure(input logic [CFG_W-1:0] len_word,
                             input logic [CFG_W-1:0] scale_word);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WINDOW_LEN;
        i_cfg_data <= len_word;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_THRESHOLD_SCALE;
        i_cfg_data <= scale_word;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_len_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_W'(1);
            2:       return CFG_W'(WINDOW_MAX_DEF);
            3:       return CFG_W'($urandom_range(WINDOW_MAX_DEF + 1, 127));
            4:       return CFG_W'($urandom_range(0, 1023));
            5:       return CFG_W'(2);
            default: return CFG_W'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_scale_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_W'(1023);
            2:       return CFG_W'(256);
            3:       return SCALE_RST;
            4:       return CFG_W'($urandom_range(0, 1023));
            default: return CFG_W'($urandom_range(128, 384));
        endcase
    endfunction

    // Pixels mostly wander around a level, so that many sit near the threshold.
    function automatic logic [PIX_W-1:0] pick_pixel(input int style, inout int level);
        level += $urandom_range(0, 16) - 8;
        if (level < 0)
            level = 0;
        if (level > PIX_MAX)
            level = PIX_MAX;
        case (style)
            0:       return PIX_W'($urandom_range(0, PIX_MAX));
            1:       return ($urandom_range(0, 1) != 0) ? PIX_W'(PIX_MAX) : '0;
            default: return PIX_W'(level);
        endcase
    endfunction

    initial begin
        int sent;
        int phase_len;
        int frame_left;
        int style;
        int level;
        logic fs;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Before any frame start, then two short frames at the reset settings.
        feed(8'd0, 1'b0);
        feed(8'd255, 1'b0);
        feed(8'd1, 1'b0);
        feed(8'd254, 1'b0);
        feed(8'd255, 1'b1);
        feed(8'd0, 1'b0);
        feed(8'd128, 1'b0);
        feed(8'd255, 1'b0);
        feed(8'd0, 1'b1);
        feed(8'd200, 1'b0);
        // A window length of zero behaves as one; largest scale.
        settle();
        configure('0, 10'd1023);
        feed(8'd0, 1'b1);
        feed(8'd1, 1'b0);
        feed(8'd255, 1'b0);
        feed(8'd0, 1'b0);
        // Length beyond the ring is clamped; upper data bits are dropped.
        settle();
        configure(10'h3FF, '0);
        feed(8'd0, 1'b0);
        feed(8'd1, 1'b0);
        feed(8'd0, 1'b1);
        // Length changes in the middle of a frame.
        settle();
        configure(CFG_W'(WINDOW_MAX_DEF), 10'd256);
        feed(8'd128, 1'b0);
        feed(8'd129, 1'b0);
        settle();
        configure(10'd1, 10'd256);
        feed(8'd128, 1'b0);
        feed(8'd129, 1'b0);
        feed(8'd127, 1'b1);

        sent  = 0;
        level = 128;
        style = 2;
        while (sent < PIXEL_TOTAL) begin
            settle();
            if (sent >= PIXEL_TOTAL - CALM_TAIL) begin
                feed_gaps    = 1'b0;
                drain_stalls <= 1'b0;
            end else begin
                feed_gaps    = ($urandom_range(0, 3) != 0);
                drain_stalls <= ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 4) != 0)
                configure(pick_len_word(), pick_scale_word());
            phase_len = $urandom_range(40, 200);
            if (phase_len > PIXEL_TOTAL - sent)
                phase_len = PIXEL_TOTAL - sent;
            // Often the phase carries on with the frame that was already open.
            frame_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
            for (int n = 0; n < phase_len; n++) begin
                if (frame_left == 0) begin
                    fs         = 1'b1;
                    frame_left = $urandom_range(1, 150);
                    level      = $urandom_range(0, PIX_MAX);
                    style      = $urandom_range(0, 5);
                end else begin
                    fs = ($urandom_range(0, 40) == 0);
                end
                frame_left--;
                feed(pick_pixel(style, level), fs);
                sent++;
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && outstanding == 0)
            $display("moving_average_threshold_tb passed");
        else
            $display("moving_average_threshold_tb failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("moving_average_threshold_tb failed");
        $finish;
    end

endmodule

[files.f]
design/mat_pkg.sv
design/mat_ram.sv
design/mat_front.sv
design/mat_back.sv
design/moving_average_threshold.sv
tb/moving_average_threshold_checker.sv
tb/moving_average_threshold_tb.sv
